// File: rtl/audio_frame_ring_fifo_defines.svh
// ----------------------------------------------------------------------------
// audio_frame_ring_fifo_defines
// assertion macros shared by the audio frame ring fifo rtl
// ----------------------------------------------------------------------------
`ifndef AUDIO_FRAME_RING_FIFO_DEFINES_SVH
`define AUDIO_FRAME_RING_FIFO_DEFINES_SVH

// condition holds at every clock edge out of reset
`define AFR_ASSERT_HOLDS(label, cond, msg) \
label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define AFR_ASSERT_IMPLY(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// antecedent implies consequent in the next cycle
`define AFR_ASSERT_NEXT(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// File: rtl/afr_pkg.sv
// ----------------------------------------------------------------------------
// afr_pkg
// widths, codes and defaults of the audio frame ring fifo
// ----------------------------------------------------------------------------
package afr_pkg;

	localparam int DEPTH_DEF      = 1024;
	localparam int FRAME_BITS_DEF = 32;
	localparam int MAX_BURST_DEF  = 64;

	localparam int MODE_W   = 2;
	localparam int FRAME_W  = 32;
	localparam int RCNT_W   = 7;
	localparam int OCC_W    = 10;
	localparam int EVT_W    = 32;
	localparam int DIU_W    = 11;
	localparam int DIU_MAX  = 2047;
	localparam int ADDR_W   = 3;
	localparam int APB_W    = 32;

	localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

	localparam logic REG_DEPTH = 1'b0;
	localparam logic REG_ZFILL = 1'b1;

endpackage

// File: rtl/afr_in_if.sv
// ----------------------------------------------------------------------------
// afr_in_if
// command channel: write, read burst or clear transactions
// ----------------------------------------------------------------------------
interface afr_in_if;
	logic                          valid;
	logic                          ready;
	logic [afr_pkg::MODE_W-1:0]    mode;
	logic [afr_pkg::FRAME_W-1:0]   frame_in;
	logic                          last_of_call;
	logic [afr_pkg::RCNT_W-1:0]    read_count;

	modport source (output valid, mode, frame_in, last_of_call, read_count, input ready);
	modport sink (input valid, mode, frame_in, last_of_call, read_count, output ready);
endinterface

// File: rtl/afr_out_if.sv
// ----------------------------------------------------------------------------
// afr_out_if
// result channel: one transaction per returned frame or status
// ----------------------------------------------------------------------------
interface afr_out_if;
	logic                        valid;
	logic                        ready;
	logic [afr_pkg::FRAME_W-1:0] frame_out;
	logic                        frame_valid;
	logic                        accepted;
	logic [afr_pkg::OCC_W-1:0]   occupancy;
	logic [afr_pkg::EVT_W-1:0]   overflow_events;
	logic [afr_pkg::EVT_W-1:0]   underflow_events;
	logic                        last;

	modport source (output valid, frame_out, frame_valid, accepted, occupancy,
		overflow_events, underflow_events, last, input ready);
	modport sink (input valid, frame_out, frame_valid, accepted, occupancy,
		overflow_events, underflow_events, last, output ready);
endinterface

// File: rtl/afr_store.sv
// ----------------------------------------------------------------------------
// afr_store
// frame storage, one write port and one read port with registered read data
// ----------------------------------------------------------------------------
module afr_store #(
	parameter int DEPTH      = afr_pkg::DEPTH_DEF,
	parameter int FRAME_BITS = afr_pkg::FRAME_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [FRAME_BITS-1:0]    wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [FRAME_BITS-1:0]    rdata
);

	logic [FRAME_BITS-1:0] mem [DEPTH];
	logic [FRAME_BITS-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/audio_frame_ring_fifo.sv
// ----------------------------------------------------------------------------
// audio_frame_ring_fifo
// ring fifo of audio frames with one slot kept empty
// ----------------------------------------------------------------------------
// cmd carries one transaction per item: a frame write, a read burst of up to
// MAX_BURST frames, or a pointer clear. res returns one transaction for a
// write, clear, unused mode or empty read, and one per returned frame for a
// read burst, with last set on the final one. status fields show the state
// after the item. a write or clear result passes through the read stage into
// the output register. a read burst is decoded when taken, then issues one
// result per cycle while res does not stall, reading the frame store for each
// stored frame. cmd is held off while a burst is in flight. configuration
// goes through the apb port while the block is idle, a rule for the user
// that the block does not enforce; writing depth_in_use clears both pointers.
// reset clears pointers, counters and the result pipeline; the frame store
// itself is not cleared. when res stalls, the output register and the read
// stage hold their data; once both are full no further memory reads issue.
// ----------------------------------------------------------------------------
module audio_frame_ring_fifo #(
	parameter int DEPTH      = afr_pkg::DEPTH_DEF,
	parameter int FRAME_BITS = afr_pkg::FRAME_BITS_DEF,
	parameter int MAX_BURST  = afr_pkg::MAX_BURST_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [afr_pkg::ADDR_W-1:0]  paddr,
	input  logic [afr_pkg::APB_W-1:0]   pwdata,
	output logic [afr_pkg::APB_W-1:0]   prdata,
	output logic                        pready,
	afr_in_if.sink                      cmd,
	afr_out_if.source                   res
);

`include "audio_frame_ring_fifo_defines.svh"

	localparam int PW      = $clog2(DEPTH);
	localparam int RW      = PW + 1;
	localparam int BW      = $clog2(MAX_BURST + 1);
	localparam int DIU_RST = (DEPTH > afr_pkg::DIU_MAX) ? afr_pkg::DIU_MAX : DEPTH;

	// configuration
	logic [afr_pkg::DIU_W-1:0] diu_q;
	logic [RW-1:0]             ring_q;
	logic                      zfill_q;

	// ring state
	logic [PW-1:0]             wp_q;
	logic [PW-1:0]             rp_q;
	logic [PW-1:0]             cnt_q;
	logic                      stored_any_q;
	logic [afr_pkg::EVT_W-1:0] ovf_q;
	logic [afr_pkg::EVT_W-1:0] unf_q;

	// burst sequencer
	logic                      busy_q;
	logic [BW-1:0]             rem_q;
	logic [BW-1:0]             take_q;

	// read stage and output register
	logic                      vld_s1;
	logic                      mem_s1;
	logic                      acc_s1;
	logic                      last_s1;
	logic                      out_vld_q;
	logic [afr_pkg::FRAME_W-1:0] frame_q;
	logic                      fvalid_q;
	logic                      acc_q;
	logic                      last_q;
	logic [afr_pkg::OCC_W-1:0] occ_q;
	logic [afr_pkg::EVT_W-1:0] ovf_out_q;
	logic [afr_pkg::EVT_W-1:0] unf_out_q;

	logic                      cfg_wr;
	logic                      cfg_sel;
	logic                      out_free;
	logic                      slot_free;
	logic                      s1_go;
	logic                      in_acc;
	logic                      issue;
	logic                      rd_en;
	logic                      single;
	logic                      load_s1;
	logic                      is_wr;
	logic                      is_rd;
	logic                      has_room;
	logic                      wr_en;
	logic [BW-1:0]             req;
	logic [BW-1:0]             take;
	logic [BW-1:0]             total;
	logic [FRAME_BITS-1:0]     rdata;

	function automatic logic [PW-1:0] advance(input logic [PW-1:0] p, input logic [RW-1:0] ring);
		logic [RW-1:0] n;
		begin
			n = {1'b0, p} + RW'(1);
			advance = (n >= ring) ? '0 : n[PW-1:0];
		end
	endfunction

	function automatic logic [RW-1:0] clamp_ring(input logic [afr_pkg::DIU_W-1:0] d);
		begin
			if (d < afr_pkg::DIU_W'(2)) begin
				clamp_ring = RW'(2);
			end else if (32'(d) > DEPTH) begin
				clamp_ring = RW'(DEPTH);
			end else begin
				clamp_ring = RW'(d);
			end
		end
	endfunction

	// apb port
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign cfg_sel = paddr[afr_pkg::ADDR_W-1];

	always_comb begin
		unique case (cfg_sel)
			afr_pkg::REG_DEPTH: prdata = afr_pkg::APB_W'(diu_q);
			afr_pkg::REG_ZFILL: prdata = afr_pkg::APB_W'(zfill_q);
			default:            prdata = '0;
		endcase
	end

	// handshake and pipeline flow
	assign out_free  = !out_vld_q || res.ready;
	assign s1_go     = vld_s1 && out_free;
	assign slot_free = !vld_s1 || out_free;
	assign cmd.ready = !busy_q && slot_free;
	assign in_acc    = cmd.valid && cmd.ready;
	assign issue     = busy_q && slot_free;
	assign rd_en     = issue && (take_q != '0);

	// item decode
	assign is_wr    = (cmd.mode == afr_pkg::MODE_WRITE);
	assign is_rd    = (cmd.mode == afr_pkg::MODE_READ);
	assign has_room = ({1'b0, cnt_q} < (ring_q - RW'(1)));
	assign wr_en    = in_acc && is_wr && has_room;

	always_comb begin
		if (cmd.read_count == '0) begin
			req = BW'(1);
		end else if (32'(cmd.read_count) > MAX_BURST) begin
			req = BW'(MAX_BURST);
		end else begin
			req = BW'(cmd.read_count);
		end
		take  = (32'(req) <= 32'(cnt_q)) ? req : BW'(cnt_q);
		total = zfill_q ? req : take;
	end

	// write, clear, unused mode and empty read give one result straight away
	assign single  = !is_rd || (total == '0);
	assign load_s1 = (in_acc && single) || issue;

	// configuration and ring state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			diu_q        <= afr_pkg::DIU_W'(DIU_RST);
			ring_q       <= RW'(DEPTH);
			zfill_q      <= 1'b0;
			wp_q         <= '0;
			rp_q         <= '0;
			cnt_q        <= '0;
			stored_any_q <= 1'b0;
			ovf_q        <= '0;
			unf_q        <= '0;
			busy_q       <= 1'b0;
			rem_q        <= '0;
			take_q       <= '0;
		end else begin
			if (cfg_wr) begin
				unique case (cfg_sel)
					afr_pkg::REG_DEPTH: begin
						diu_q  <= pwdata[afr_pkg::DIU_W-1:0];
						ring_q <= clamp_ring(pwdata[afr_pkg::DIU_W-1:0]);
						wp_q   <= '0;
						rp_q   <= '0;
						cnt_q  <= '0;
					end
					afr_pkg::REG_ZFILL: begin
						zfill_q <= pwdata[0];
					end
					default: begin
					end
				endcase
			end
			if (in_acc) begin
				unique case (cmd.mode)
					afr_pkg::MODE_WRITE: begin
						if (has_room) begin
							wp_q  <= advance(wp_q, ring_q);
							cnt_q <= cnt_q + PW'(1);
						end
						if (cmd.last_of_call) begin
							if (!(stored_any_q || has_room)) begin
								ovf_q <= ovf_q + afr_pkg::EVT_W'(1);
							end
							stored_any_q <= 1'b0;
						end else begin
							stored_any_q <= stored_any_q || has_room;
						end
					end
					afr_pkg::MODE_READ: begin
						cnt_q <= cnt_q - PW'(take);
						if (take == '0) begin
							unf_q <= unf_q + afr_pkg::EVT_W'(1);
						end
						if (total != '0) begin
							busy_q <= 1'b1;
							rem_q  <= total;
							take_q <= take;
						end
					end
					afr_pkg::MODE_CLEAR: begin
						wp_q  <= '0;
						rp_q  <= '0;
						cnt_q <= '0;
					end
					default: begin
					end
				endcase
			end
			if (issue) begin
				if (rd_en) begin
					rp_q   <= advance(rp_q, ring_q);
					take_q <= take_q - BW'(1);
				end
				rem_q <= rem_q - BW'(1);
				if (rem_q == BW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	afr_store #(
		.DEPTH      (DEPTH),
		.FRAME_BITS (FRAME_BITS)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wp_q),
		.wdata (FRAME_BITS'(cmd.frame_in)),
		.re    (rd_en),
		.raddr (rp_q),
		.rdata (rdata)
	);

	// read stage: control beside the memory read in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (load_s1) begin
			vld_s1 <= 1'b1;
		end else if (s1_go) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			mem_s1  <= (take_q != '0);
			acc_s1  <= 1'b0;
			last_s1 <= (rem_q == BW'(1));
		end else if (in_acc && single) begin
			mem_s1  <= 1'b0;
			acc_s1  <= is_wr && has_room;
			last_s1 <= 1'b1;
		end
	end

	// output register, status sampled after the item has updated it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (s1_go) begin
			out_vld_q <= 1'b1;
		end else if (res.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			frame_q   <= mem_s1 ? afr_pkg::FRAME_W'(rdata) : '0;
			fvalid_q  <= mem_s1;
			acc_q     <= acc_s1;
			last_q    <= last_s1;
			occ_q     <= afr_pkg::OCC_W'(cnt_q);
			ovf_out_q <= ovf_q;
			unf_out_q <= unf_q;
		end
	end

	assign res.valid            = out_vld_q;
	assign res.frame_out        = frame_q;
	assign res.frame_valid      = fvalid_q;
	assign res.accepted         = acc_q;
	assign res.last             = last_q;
	assign res.occupancy        = occ_q;
	assign res.overflow_events  = ovf_out_q;
	assign res.underflow_events = unf_out_q;

	`AFR_ASSERT_HOLDS(a_occ_bound, ({1'b0, cnt_q} < ring_q), "occupancy reached ring size")
	`AFR_ASSERT_HOLDS(a_ptr_in_ring, ({1'b0, wp_q} < ring_q) && ({1'b0, rp_q} < ring_q), "pointer outside ring")
	`AFR_ASSERT_IMPLY(a_burst_counts, busy_q, (take_q <= rem_q) && (rem_q != '0), "burst counters inconsistent")
	`AFR_ASSERT_NEXT(a_s1_held, vld_s1 && !out_free, vld_s1, "read stage dropped a stalled result")

endmodule
